@@ rtl/dsr_pkg.sv @@
// shared widths, codes and types of the disk request scheduler
package dsr_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SECTOR_W   = 10;
  localparam int unsigned ARRIVAL_W  = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SEEK_W     = 10;
  localparam int unsigned CLOCK_W    = 32;
  localparam int unsigned MOVE_W     = 32;
  localparam int unsigned PENDING_W  = 5;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned COST_W     = SECTOR_W + 1;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_CYLINDERS   = 1000;

  // commands
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVICE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SERVED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICKED    = 3'd4;

  // selection policies
  localparam logic [POLICY_W-1:0] POL_FCFS  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_SSTF  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_CSCAN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 1'd1;

  localparam logic [COST_W-1:0]  REVERSE_PENALTY = 11'd50;
  localparam logic [CLOCK_W-1:0] TICK_TENTHS     = 32'd10;
  localparam logic [SEEK_W-1:0]  SEEK_MAX        = '1;

  typedef struct packed {
    logic                latch;       // take the request fields
    logic                scan_start;  // reset walker and best-so-far
    logic                walk_scan;   // step walker, evaluate entries
    logic                walk_shift;  // step walker, move entries down
    logic                enq;         // append request
    logic                tick;        // advance clock
    logic                cost;        // compute cost of the chosen entry
    logic                apply;       // update head, clock, movement
    logic                dec;         // drop one entry from the count
    logic                res_load;    // load the result register
    logic [STATUS_W-1:0] res_status;
  } dsr_cmd_t;

  typedef struct packed {
    logic full;
    logic walk_done;
    logic serviceable;
  } dsr_stat_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SECTOR_W-1:0]  served_sector;
    logic [SEEK_W-1:0]    seek_tenths;
    logic [CLOCK_W-1:0]   clock_tenths;
    logic [MOVE_W-1:0]    movement_total;
    logic [PENDING_W-1:0] pending_count;
  } dsr_res_t;

endpackage

@@ rtl/dsr_if.sv @@
// request and result channel interfaces
interface dsr_req_if import dsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [SECTOR_W-1:0]  sector;
  logic [ARRIVAL_W-1:0] arrival;

  modport source (output valid, command, sector, arrival, input ready);
  modport sink   (input valid, command, sector, arrival, output ready);
endinterface

interface dsr_res_if import dsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SECTOR_W-1:0]  served_sector;
  logic [SEEK_W-1:0]    seek_tenths;
  logic [CLOCK_W-1:0]   clock_tenths;
  logic [MOVE_W-1:0]    movement_total;
  logic [PENDING_W-1:0] pending_count;

  modport source (output valid, status, served_sector, seek_tenths, clock_tenths,
                  movement_total, pending_count, input ready);
  modport sink   (input valid, status, served_sector, seek_tenths, clock_tenths,
                  movement_total, pending_count, output ready);
endinterface

@@ rtl/dsr_ctrl.sv @@
// controller state machine of the disk request scheduler
module dsr_ctrl import dsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_command_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dsr_stat_t        stat_i,
  output dsr_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ,
    S_TICK,
    S_SCAN,
    S_COST,
    S_APPLY,
    S_SHIFT,
    S_RESULT
  } state_e;

  state_e              state_q, state_d;
  logic                out_valid_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    cmd_o        = '0;
    cmd_o.res_status = res_status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch = 1'b1;
          case (in_command_i)
            CMD_ENQUEUE: state_d = S_ENQ;
            CMD_TICK:    state_d = S_TICK;
            CMD_SERVICE: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
            default: begin
              res_status_d = ST_NOT_READY;
              state_d      = S_RESULT;
            end
          endcase
        end
      end
      S_ENQ: begin
        cmd_o.enq    = !stat_i.full;
        res_status_d = stat_i.full ? ST_FULL : ST_ENQUEUED;
        state_d      = S_RESULT;
      end
      S_TICK: begin
        cmd_o.tick   = 1'b1;
        res_status_d = ST_TICKED;
        state_d      = S_RESULT;
      end
      S_SCAN: begin
        cmd_o.walk_scan = 1'b1;
        if (stat_i.walk_done) begin
          if (stat_i.serviceable) begin
            state_d = S_COST;
          end else begin
            res_status_d = ST_NOT_READY;
            state_d      = S_RESULT;
          end
        end
      end
      S_COST: begin
        cmd_o.cost = 1'b1;
        state_d    = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.walk_shift = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.dec    = 1'b1;
          res_status_d = ST_SERVED;
          state_d      = S_RESULT;
        end
      end
      S_RESULT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_NOT_READY;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/dsr_datapath.sv @@
// queue memory, head and clock state, selection scan and result register
module dsr_datapath import dsr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned CYLINDERS   = DEF_CYLINDERS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [SECTOR_W-1:0]   in_sector_i,
  input  logic [ARRIVAL_W-1:0]  in_arrival_i,
  input  dsr_cmd_t              cmd_i,
  output dsr_stat_t             stat_o,
  output dsr_res_t              res_o
);

  localparam int unsigned IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WORD_W   = ARRIVAL_W + SECTOR_W;
  localparam int unsigned ARR10_W  = ARRIVAL_W + 4;
  localparam int unsigned CYL_BITS = $clog2(CYLINDERS + 1);
  localparam int unsigned CMP_W    = ((CYL_BITS > SECTOR_W) ? CYL_BITS : SECTOR_W) + 1;
  localparam logic [CMP_W-1:0] CYL_FULL = CMP_W'(CYLINDERS);
  localparam logic [CMP_W-1:0] CYL_HALF = CMP_W'(CYLINDERS / 2);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

  // configuration and architectural state
  logic [POLICY_W-1:0] policy_q;
  logic                served_any_q;
  logic [SECTOR_W-1:0] head_q;
  logic                fwd_q;
  logic [CLOCK_W-1:0]  clock_q;
  logic [MOVE_W-1:0]   move_q;
  logic [CNT_W-1:0]    count_q;

  // latched request
  logic [SECTOR_W-1:0]  req_sec_q;
  logic [ARRIVAL_W-1:0] req_arr_q;

  // queue memory, one word per entry: arrival above sector
  logic [WORD_W-1:0] mem [QUEUE_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // walker shared by the scan and the compaction
  logic [CNT_W-1:0] ptr_q;
  logic             pv_q;
  logic [IDX_W-1:0] ptag_q;
  logic             walk;
  logic             rd_en;

  // best-so-far of the scan
  logic                found_q;
  logic                front_ready_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [COST_W-1:0]   best_key_q;
  logic [SECTOR_W-1:0] best_sec_q;
  logic [SECTOR_W-1:0] front_sec_q;

  // chosen entry
  logic [SECTOR_W-1:0] dest_q;
  logic [IDX_W-1:0]    pick_q;
  logic [SECTOR_W-1:0] dist_q;
  logic [COST_W-1:0]   cost_q;
  logic                rev_q;

  dsr_res_t res_q;

  function automatic logic [SECTOR_W-1:0] raw_dist(input logic [SECTOR_W-1:0] s,
                                                   input logic [SECTOR_W-1:0] h);
    return (s >= h) ? (s - h) : (h - s);
  endfunction

  // fold at half the disk; beyond a full disk wraps by the disk size
  function automatic logic [SECTOR_W-1:0] fold_dist(input logic [SECTOR_W-1:0] raw);
    logic [CMP_W-1:0] r;
    logic [CMP_W-1:0] f;
    r = CMP_W'(raw);
    if (r > CYL_HALF) begin
      if (r < CYL_FULL) begin
        f = CYL_FULL - r;
      end else begin
        f = r - CYL_FULL;
      end
    end else begin
      f = r;
    end
    return f[SECTOR_W-1:0];
  endfunction

  function automatic logic reverses(input logic [SECTOR_W-1:0] s,
                                    input logic [SECTOR_W-1:0] h,
                                    input logic                fwd);
    return ((s < h) && fwd) || ((s > h) && !fwd);
  endfunction

  // entry evaluation during the scan
  logic [SECTOR_W-1:0]  ev_sec;
  logic [ARRIVAL_W-1:0] ev_arr;
  logic [ARR10_W-1:0]   ev_arr10;
  logic                 ev_ready;
  logic                 ev_ahead;
  logic [SECTOR_W-1:0]  ev_raw;
  logic [COST_W-1:0]    ev_cost;
  logic [COST_W-1:0]    ev_key;
  logic                 ev_cand;
  logic                 is_sstf;
  logic                 is_cscan;

  assign ev_sec   = rdata_q[SECTOR_W-1:0];
  assign ev_arr   = rdata_q[WORD_W-1:SECTOR_W];
  assign ev_arr10 = {1'b0, ev_arr, 3'b000} + {3'b000, ev_arr, 1'b0};
  assign ev_ready = (CLOCK_W'(ev_arr10) <= clock_q);
  assign ev_ahead = fwd_q ? (ev_sec > head_q) : (ev_sec < head_q);
  assign ev_raw   = raw_dist(ev_sec, head_q);
  assign ev_cost  = COST_W'(fold_dist(ev_raw))
                  + (reverses(ev_sec, head_q, fwd_q) ? REVERSE_PENALTY : '0);
  assign is_sstf  = (policy_q == POL_SSTF);
  assign is_cscan = (policy_q == POL_CSCAN);
  assign ev_key   = is_sstf ? ev_cost : COST_W'(ev_raw);

  // the front entry always seeds the shortest-seek search
  always_comb begin
    if (is_sstf) begin
      ev_cand = (ptag_q == '0) || ev_ready;
    end else if (is_cscan) begin
      ev_cand = ev_ready && ev_ahead;
    end else begin
      ev_cand = 1'b0;
    end
  end

  // chosen entry cost
  logic [SECTOR_W-1:0] ch_sec;
  logic [SECTOR_W-1:0] ch_dist;
  logic                ch_rev;

  assign ch_sec  = found_q ? best_sec_q : front_sec_q;
  assign ch_dist = fold_dist(raw_dist(ch_sec, head_q));
  assign ch_rev  = reverses(ch_sec, head_q, fwd_q);

  logic [MOVE_W:0] move_sum;
  assign move_sum = {1'b0, move_q} + (MOVE_W + 1)'(dist_q);

  assign walk  = cmd_i.walk_scan || cmd_i.walk_shift;
  assign rd_en = walk && (ptr_q < count_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = {req_arr_q, req_sec_q};
    if (cmd_i.enq) begin
      mem_we = 1'b1;
    end else if (cmd_i.walk_shift && pv_q) begin
      // entry read in the previous cycle moves down by one place
      mem_we    = 1'b1;
      mem_waddr = ptag_q - IDX_W'(1);
      mem_wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[ptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_sec_q <= in_sector_i;
      req_arr_q <= in_arrival_i;
    end
    if (cmd_i.walk_scan && pv_q) begin
      if (ptag_q == '0) begin
        front_sec_q <= ev_sec;
      end
      if (ev_cand && (!found_q || (ev_key < best_key_q))) begin
        best_idx_q <= ptag_q;
        best_key_q <= ev_key;
        best_sec_q <= ev_sec;
      end
    end
    if (cmd_i.cost) begin
      dest_q <= ch_sec;
      pick_q <= found_q ? best_idx_q : '0;
      dist_q <= ch_dist;
      cost_q <= COST_W'(ch_dist) + (ch_rev ? REVERSE_PENALTY : '0);
      rev_q  <= ch_rev;
    end
    if (cmd_i.res_load) begin
      res_q.status         <= cmd_i.res_status;
      res_q.served_sector  <= head_q;
      res_q.seek_tenths    <= (cmd_i.res_status != ST_SERVED) ? '0 :
                              (cost_q > COST_W'(SEEK_MAX)) ? SEEK_MAX :
                              cost_q[SEEK_W-1:0];
      res_q.clock_tenths   <= clock_q;
      res_q.movement_total <= move_q;
      res_q.pending_count  <= PENDING_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q         <= '0;
      pv_q          <= 1'b0;
      ptag_q        <= '0;
      found_q       <= 1'b0;
      front_ready_q <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        ptr_q         <= '0;
        pv_q          <= 1'b0;
        found_q       <= 1'b0;
        front_ready_q <= 1'b0;
      end else if (cmd_i.apply) begin
        ptr_q <= CNT_W'(pick_q) + CNT_W'(1);
        pv_q  <= 1'b0;
      end else if (walk) begin
        if (rd_en) begin
          ptr_q  <= ptr_q + CNT_W'(1);
          pv_q   <= 1'b1;
          ptag_q <= ptr_q[IDX_W-1:0];
        end else begin
          pv_q <= 1'b0;
        end
      end
      if (cmd_i.walk_scan && pv_q) begin
        if (ptag_q == '0) begin
          front_ready_q <= ev_ready;
        end
        if (ev_cand && (!found_q || (ev_key < best_key_q))) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= POL_FCFS;
      served_any_q <= 1'b0;
      head_q       <= '0;
      fwd_q        <= 1'b1;
      clock_q      <= '0;
      move_q       <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLICY: policy_q <= cfg_wdata_i[POLICY_W-1:0];
          REG_START_HEAD: begin
            if (!served_any_q) begin
              head_q <= cfg_wdata_i[SECTOR_W-1:0];
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.enq) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.tick) begin
        clock_q <= clock_q + TICK_TENTHS;
      end
      if (cmd_i.apply) begin
        head_q       <= dest_q;
        fwd_q        <= fwd_q ^ rev_q;
        clock_q      <= clock_q + CLOCK_W'(cost_q);
        move_q       <= move_sum[MOVE_W] ? '1 : move_sum[MOVE_W-1:0];
        served_any_q <= 1'b1;
      end
    end
  end

  assign stat_o.full        = (count_q >= DEPTH_C);
  assign stat_o.walk_done   = (ptr_q >= count_q) && !pv_q;
  assign stat_o.serviceable = front_ready_q;
  assign res_o              = res_q;

endmodule

@@ rtl/disk_request_scheduler_unit.sv @@
// Disk request scheduler: an arrival-ordered queue of QUEUE_DEPTH requests served
// first-come, shortest-seek or circular-scan, with head, direction, tenths clock and
// a saturating movement total. One request is worked on at a time. A service reads the
// queue memory once per entry to pick the request and once per remaining entry to close
// the gap it leaves. A new request is taken while the previous result waits in the output
// register. The start_head register also sets the head until the first service.
module disk_request_scheduler_unit import dsr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int unsigned CYLINDERS   = DEF_CYLINDERS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dsr_req_if.sink               req_i,
  dsr_res_if.source             res_o
);

  dsr_cmd_t  cmd;
  dsr_stat_t stat;
  dsr_res_t  res;

  dsr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (req_i.ready),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  dsr_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CYLINDERS   (CYLINDERS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_sector_i  (req_i.sector),
    .in_arrival_i (req_i.arrival),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .res_o        (res)
  );

  assign res_o.status         = res.status;
  assign res_o.served_sector  = res.served_sector;
  assign res_o.seek_tenths    = res.seek_tenths;
  assign res_o.clock_tenths   = res.clock_tenths;
  assign res_o.movement_total = res.movement_total;
  assign res_o.pending_count  = res.pending_count;

endmodule
